@@ rtl/rtm_pkg.sv @@
// Package with the widths, codes and state type of the range table block.
`timescale 1ns / 1ps
package rtm_pkg;
  localparam int MAX_RANGES = 256;
  localparam int KEY_W      = 50;
  localparam int TOTAL_W    = KEY_W + 1;
  localparam int CNT_W      = 32;
  localparam int ADDR_W     = $clog2(MAX_RANGES);
  localparam int USED_W     = ADDR_W + 1;

  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_QUERY  = 2'd1;
  localparam logic [1:0] CMD_REPORT = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_INVERTED = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_QUERY,
    S_FIND,
    S_EXTEND,
    S_OUT
  } state_t;
endpackage

@@ rtl/range_table_match_and_union_core.sv @@
// Top level of the range table: range store, membership test and union size.
`timescale 1ns / 1ps
// Channel  | handshake            | payload
// input    | in_valid / in_stall  | cmd, range_low, range_high, query_key
// output   | out_valid / out_stall| status, is_match, match_count, covered_total
//
// Load and clear go straight from idle to the output state. A query scans
// the table once through one registered memory read port and one compare
// unit. A report walks the union one merged segment at a time: a find pass
// picks the next uncovered start, then extend passes repeat until the segment
// stops growing.
// Reset is synchronous and clears the table count, counter and control state.
// A result waiting under out_stall does not block the next item from being
// accepted, but a finished item cannot leave until the output register frees.
module range_table_match_and_union_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                cmd,
  input  logic [rtm_pkg::KEY_W-1:0] range_low,
  input  logic [rtm_pkg::KEY_W-1:0] range_high,
  input  logic [rtm_pkg::KEY_W-1:0] query_key,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                status,
  output logic                      is_match,
  output logic [rtm_pkg::CNT_W-1:0] match_count,
  output logic [rtm_pkg::TOTAL_W-1:0] covered_total
);
  import rtm_pkg::*;

  // Range store: one write port for loads, one registered read port for scans.
  logic [KEY_W-1:0] low_mem  [MAX_RANGES];
  logic [KEY_W-1:0] high_mem [MAX_RANGES];

  state_t state, state_next;
  logic [USED_W-1:0] entries_used;
  logic [CNT_W-1:0]  hit_counter;

  // Scan machinery: issue counter and the registered read data.
  logic [USED_W-1:0] iss;
  logic              rd_vld;
  logic [KEY_W-1:0]  rd_low, rd_high;
  logic              issue, pass_end, in_acc, out_free;

  // Per-item working registers.
  logic [KEY_W-1:0]   key_q;
  logic               hit;
  logic               found, changed;
  logic [KEY_W-1:0]   best, seg_s, seg_e;
  logic [TOTAL_W-1:0] pos, total;
  logic [1:0]         res_status;
  logic               res_match;
  logic [TOTAL_W-1:0] res_total;
  logic [KEY_W-1:0]   cand;

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign pass_end = (iss == entries_used) && !rd_vld;

  // The candidate start of a segment is the later of the range's low bound
  // and the first key that is not yet accounted for.
  assign cand = ({1'b0, rd_low} >= pos) ? rd_low : pos[KEY_W-1:0];

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          unique case (cmd)
            CMD_QUERY:  state_next = S_QUERY;
            CMD_REPORT: state_next = S_FIND;
            default:    state_next = S_OUT;
          endcase
        end
      end
      S_QUERY:  if (pass_end) state_next = S_OUT;
      S_FIND:   if (pass_end) state_next = found ? S_EXTEND : S_OUT;
      S_EXTEND: if (pass_end && !changed) state_next = S_FIND;
      S_OUT:    if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state != S_IDLE);
    issue    = 1'b0;
    unique case (state)
      S_QUERY, S_FIND, S_EXTEND: issue = (iss < entries_used);
      default:                   issue = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Memory write and registered read.
  always_ff @(posedge clk) begin
    if (in_acc && cmd == CMD_LOAD && entries_used < USED_W'(MAX_RANGES)
        && range_low <= range_high) begin
      low_mem[entries_used[ADDR_W-1:0]]  <= range_low;
      high_mem[entries_used[ADDR_W-1:0]] <= range_high;
    end
    if (issue) begin
      rd_low  <= low_mem[iss[ADDR_W-1:0]];
      rd_high <= high_mem[iss[ADDR_W-1:0]];
    end
  end

  // Control counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      entries_used <= '0;
      hit_counter  <= '0;
      rd_vld       <= 1'b0;
      iss          <= '0;
      out_valid    <= 1'b0;
    end else begin
      rd_vld <= issue;
      if (issue) begin
        iss <= iss + 1'b1;
      end else if (state == S_IDLE || pass_end) begin
        iss <= '0;
      end
      if (in_acc && cmd == CMD_LOAD && entries_used < USED_W'(MAX_RANGES)
          && range_low <= range_high) begin
        entries_used <= entries_used + 1'b1;
      end
      if (in_acc && cmd == CMD_CLEAR) begin
        entries_used <= '0;
        hit_counter  <= '0;
      end
      if (state == S_QUERY && pass_end && hit && hit_counter != '1) begin
        hit_counter <= hit_counter + 1'b1;
      end
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Per-item datapath, including the compare logic of the scans.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      key_q      <= query_key;
      hit        <= 1'b0;
      found      <= 1'b0;
      pos        <= '0;
      total      <= '0;
      res_status <= ST_OK;
      res_match  <= 1'b0;
      res_total  <= '0;
      if (cmd == CMD_LOAD) begin
        if (entries_used >= USED_W'(MAX_RANGES)) begin
          res_status <= ST_FULL;
        end else if (range_low > range_high) begin
          res_status <= ST_INVERTED;
        end
      end
    end
    unique case (state)
      S_QUERY: begin
        if (rd_vld && key_q >= rd_low && key_q <= rd_high) begin
          hit <= 1'b1;
        end
        if (pass_end) begin
          res_match <= hit;
        end
      end
      S_FIND: begin
        if (rd_vld && {1'b0, rd_high} >= pos && (!found || cand < best)) begin
          best  <= cand;
          found <= 1'b1;
        end
        if (pass_end) begin
          if (found) begin
            seg_s   <= best;
            seg_e   <= best;
            changed <= 1'b0;
          end else begin
            res_total <= total;
          end
        end
      end
      S_EXTEND: begin
        if (rd_vld && rd_low <= seg_e && rd_high > seg_e) begin
          seg_e   <= rd_high;
          changed <= 1'b1;
        end
        if (pass_end) begin
          changed <= 1'b0;
          if (!changed) begin
            total <= total + {1'b0, seg_e} - {1'b0, seg_s} + 1'b1;
            pos   <= {1'b0, seg_e} + 1'b1;
            found <= 1'b0;
          end
        end
      end
      default: ;
    endcase
    if (state == S_OUT && out_free) begin
      status        <= res_status;
      is_match      <= res_match;
      match_count   <= hit_counter;
      covered_total <= res_total;
    end
  end

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    entries_used <= USED_W'(MAX_RANGES))
    else $error("entry count beyond table depth");

  a_seg_order: assert property (@(posedge clk) disable iff (rst)
    state == S_EXTEND |-> seg_e >= seg_s)
    else $error("segment end before its start");

  a_hit_drop: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && hit_counter < $past(hit_counter)
      |-> $past(in_acc && cmd == CMD_CLEAR))
    else $error("hit counter fell without a clear");

  a_used_change: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && entries_used != $past(entries_used) |-> $past(in_acc))
    else $error("entry count changed without an accepted item");
endmodule

@@ verif/range_table_match_and_union_core_tb.sv @@
// Self-checking testbench for the range table match and union core.
`timescale 1ns / 1ps
module range_table_match_and_union_core_tb;
  import rtm_pkg::*;

  typedef struct packed {
    logic [1:0]       op;
    logic [KEY_W-1:0] lo;
    logic [KEY_W-1:0] hi;
    logic [KEY_W-1:0] key;
  } cmd_item_t;

  typedef struct packed {
    logic [1:0]         st;
    logic               hit;
    logic [CNT_W-1:0]   cnt;
    logic [TOTAL_W-1:0] total;
  } answer_t;

  localparam logic [KEY_W-1:0] KEY_MAX   = '1;
  localparam int               CYCLE_CAP = 4000000;

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall;
  logic [1:0] cmd, status;
  logic [KEY_W-1:0] range_low, range_high, query_key;
  logic is_match;
  logic [CNT_W-1:0] match_count;
  logic [TOTAL_W-1:0] covered_total;

  range_table_match_and_union_core DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .range_low(range_low), .range_high(range_high), .query_key(query_key),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .is_match(is_match), .match_count(match_count),
    .covered_total(covered_total)
  );

  // Own copy of the table, used to predict every answer.
  logic [KEY_W-1:0] tbl_lo [MAX_RANGES];
  logic [KEY_W-1:0] tbl_hi [MAX_RANGES];
  int unsigned      tbl_used;
  logic [CNT_W-1:0] hits;

  cmd_item_t pending_items[$];
  answer_t   expected_answers[$];
  // Ranges the generator has loaded since the last clear, for aiming queries.
  logic [KEY_W-1:0] gen_lo[$], gen_hi[$];

  int  errors, cycles, accepted, gap, hold;
  bit  took_item, long_hold_done, quiet_mode;
  int  n_load, n_query, n_report, n_clear, n_hit, n_full, n_inv;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [TOTAL_W-1:0] union_length();
    logic [KEY_W-1:0] s_lo [MAX_RANGES];
    logic [KEY_W-1:0] s_hi [MAX_RANGES];
    logic [63:0] sum, c_lo, c_hi;
    int j;
    if (tbl_used == 0) return '0;
    for (int i = 0; i < tbl_used; i++) begin
      j = i;
      while (j > 0 && s_lo[j-1] > tbl_lo[i]) begin
        s_lo[j] = s_lo[j-1];
        s_hi[j] = s_hi[j-1];
        j--;
      end
      s_lo[j] = tbl_lo[i];
      s_hi[j] = tbl_hi[i];
    end
    sum = 0;
    c_lo = s_lo[0];
    c_hi = s_hi[0];
    for (int i = 1; i < tbl_used; i++) begin
      if (s_lo[i] <= c_hi) begin
        if (s_hi[i] > c_hi) c_hi = s_hi[i];
      end else begin
        sum += c_hi - c_lo + 1;
        c_lo = s_lo[i];
        c_hi = s_hi[i];
      end
    end
    sum += c_hi - c_lo + 1;
    return sum[TOTAL_W-1:0];
  endfunction

  function automatic answer_t apply_command(cmd_item_t it);
    answer_t a;
    a = '0;
    case (it.op)
      CMD_LOAD: begin
        n_load++;
        if (tbl_used >= MAX_RANGES) begin
          a.st = ST_FULL;
          n_full++;
        end else if (it.lo > it.hi) begin
          a.st = ST_INVERTED;
          n_inv++;
        end else begin
          tbl_lo[tbl_used] = it.lo;
          tbl_hi[tbl_used] = it.hi;
          tbl_used++;
        end
      end
      CMD_QUERY: begin
        n_query++;
        for (int i = 0; i < tbl_used; i++)
          if (it.key >= tbl_lo[i] && it.key <= tbl_hi[i]) a.hit = 1'b1;
        if (a.hit) begin
          n_hit++;
          if (hits != '1) hits++;
        end
      end
      CMD_REPORT: begin
        n_report++;
        a.total = union_length();
      end
      default: begin
        n_clear++;
        tbl_used = 0;
        hits = '0;
      end
    endcase
    a.cnt = hits;
    return a;
  endfunction

  // Generator helpers.
  function automatic logic [KEY_W-1:0] rand_key();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[KEY_W-1:0];
  endfunction

  task automatic push(logic [1:0] op, logic [KEY_W-1:0] lo, logic [KEY_W-1:0] hi,
                      logic [KEY_W-1:0] key);
    cmd_item_t it;
    it = '{op, lo, hi, key};
    pending_items.insert(pending_items.size(), it);
    if (op == CMD_CLEAR) begin
      gen_lo.delete();
      gen_hi.delete();
    end else if (op == CMD_LOAD && lo <= hi && gen_lo.size() < MAX_RANGES) begin
      gen_lo.insert(gen_lo.size(), lo);
      gen_hi.insert(gen_hi.size(), hi);
    end
  endtask

  // Sender: presents queued items at the falling edge with random gaps.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap = 0;
    end else if (!in_valid || took_item) begin
      if (took_item) begin
        if ($urandom_range(0, 199) == 0) quiet_mode = ~quiet_mode;
        if (quiet_mode) gap = 0;
        else begin
          case ($urandom_range(0, 19))
            0:       gap = $urandom_range(10, 40);
            1, 2, 3: gap = $urandom_range(1, 3);
            default: gap = 0;
          endcase
        end
      end
      if (gap > 0) begin
        gap--;
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        cmd_item_t it;
        it = pending_items.pop_front();
        in_valid   <= 1'b1;
        cmd        <= it.op;
        range_low  <= it.lo;
        range_high <= it.hi;
        query_key  <= it.key;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off so the block backs up.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold = 0;
    end else begin
      if (!long_hold_done && accepted >= 300) begin
        long_hold_done = 1'b1;
        hold = 3000;
      end
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else if (quiet_mode) begin
        out_stall <= 1'b0;
      end else begin
        case ($urandom_range(0, 39))
          0:          hold = $urandom_range(10, 60);
          1, 2, 3, 4: hold = $urandom_range(1, 3);
          default:    hold = 0;
        endcase
        out_stall <= (hold > 0);
      end
    end
  end

  // Monitor: predicts on every accepted item, checks every accepted answer.
  always @(posedge clk) begin
    took_item <= !rst && in_valid && !in_stall;
    if (!rst) begin
      cycles++;
      if (in_valid && !in_stall) begin
        answer_t p;
        accepted++;
        p = apply_command('{cmd, range_low, range_high, query_key});
        expected_answers.insert(expected_answers.size(), p);
      end
      if (out_valid && !out_stall) begin
        if (expected_answers.size() == 0) begin
          errors++;
          $display("%0t: unexpected answer status=%0d match=%0b count=%0d total=%0d",
                   $time, status, is_match, match_count, covered_total);
        end else begin
          answer_t e;
          e = expected_answers.pop_front();
          if (status !== e.st) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $time, e.st, status);
          end
          if (is_match !== e.hit) begin
            errors++;
            $display("%0t: is_match expected %0b actual %0b", $time, e.hit, is_match);
          end
          if (match_count !== e.cnt) begin
            errors++;
            $display("%0t: match_count expected %0d actual %0d", $time, e.cnt,
                     match_count);
          end
          if (covered_total !== e.total) begin
            errors++;
            $display("%0t: covered_total expected %0d actual %0d", $time, e.total,
                     covered_total);
          end
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    if (cycles > CYCLE_CAP) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int n, ops, pick;
    logic [KEY_W-1:0] base, span, a, b;
    rst = 1'b1;
    in_valid = 1'b0;
    out_stall = 1'b0;
    cmd = CMD_CLEAR;
    range_low = '0;
    range_high = '0;
    query_key = '0;
    tbl_used = 0;
    hits = '0;

    // Directed: empty table, extreme bounds, inverted and adjacent ranges.
    push(CMD_REPORT, '0, '0, '0);
    push(CMD_QUERY, '0, '0, '0);
    push(CMD_LOAD, 50'd5, 50'd4, '0);
    push(CMD_LOAD, '0, '0, '0);
    push(CMD_LOAD, KEY_MAX, KEY_MAX, '0);
    push(CMD_QUERY, '0, '0, '0);
    push(CMD_QUERY, '0, '0, KEY_MAX);
    push(CMD_QUERY, '0, '0, 50'd1);
    push(CMD_REPORT, '0, '0, '0);
    push(CMD_LOAD, '0, KEY_MAX, '0);
    push(CMD_REPORT, '0, '0, '0);
    push(CMD_QUERY, '0, '0, 50'h2_0000_0000_1234);
    push(CMD_LOAD, KEY_MAX, '0, '0);
    push(CMD_CLEAR, '0, '0, '0);
    push(CMD_LOAD, 50'd10, 50'd19, '0);
    push(CMD_LOAD, 50'd20, 50'd29, '0);
    push(CMD_LOAD, 50'd15, 50'd25, '0);
    push(CMD_REPORT, '0, '0, '0);
    push(CMD_QUERY, '0, '0, 50'd9);
    push(CMD_QUERY, '0, '0, 50'd30);
    push(CMD_QUERY, '0, '0, 50'd20);
    push(CMD_CLEAR, '0, '0, '0);
    push(CMD_REPORT, '0, '0, '0);

    // Random: clear, fill with ranges clustered in one region, then mixed work.
    while (pending_items.size() < 1700) begin
      push(CMD_CLEAR, '0, '0, '0);
      n = ($urandom_range(0, 99) < 3) ? 262 : $urandom_range(1, 10);
      base = ($urandom_range(0, 3) == 0) ? '0 : rand_key();
      span = ($urandom_range(0, 3) == 0) ? KEY_MAX
                                         : (50'd1 << $urandom_range(2, 40)) - 50'd1;
      for (int i = 0; i < n; i++) begin
        a = base + (rand_key() & span);
        b = a + (rand_key() & (span >> $urandom_range(0, 4)));
        if (b < a) b = KEY_MAX;
        if ($urandom_range(0, 9) == 0) push(CMD_LOAD, b + 1, a, '0);
        else push(CMD_LOAD, a, b, '0);
      end
      ops = $urandom_range(5, 15);
      for (int i = 0; i < ops; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          if (gen_lo.size() > 0 && $urandom_range(0, 9) < 6) begin
            int k;
            k = $urandom_range(0, gen_lo.size() - 1);
            case ($urandom_range(0, 3))
              0: a = gen_lo[k];
              1: a = gen_hi[k];
              2: a = gen_lo[k] - 1;
              default: a = gen_hi[k] + 1;
            endcase
          end else begin
            a = base + (rand_key() & span);
          end
          push(CMD_QUERY, rand_key(), rand_key(), a);
        end else if (pick < 70) begin
          push(CMD_REPORT, rand_key(), rand_key(), rand_key());
        end else if (pick < 95) begin
          a = base + (rand_key() & span);
          b = a + (rand_key() & span);
          if ($urandom_range(0, 9) == 0) push(CMD_LOAD, b + 1, a, rand_key());
          else push(CMD_LOAD, a, (b < a) ? KEY_MAX : b, rand_key());
        end else begin
          push(CMD_CLEAR, rand_key(), rand_key(), rand_key());
        end
      end
    end

    repeat (5) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    wait (pending_items.size() == 0 && !in_valid);
    wait (expected_answers.size() == 0);
    repeat (50) @(posedge clk);

    $display("Covered %0d loads (%0d refused full, %0d inverted), %0d queries (%0d hits),",
             n_load, n_full, n_inv, n_query, n_hit);
    $display("%0d union reports and %0d clears in %0d cycles.", n_report, n_clear, cycles);
    if (errors == 0 && expected_answers.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

@@ sim.f @@
rtl/rtm_pkg.sv
rtl/range_table_match_and_union_core.sv
verif/range_table_match_and_union_core_tb.sv
